[sv/rotating_key_xor_cipher_core_defines.svh]
// Assertion macros for the rotating key XOR cipher core.
`ifndef ROTATING_KEY_XOR_CIPHER_CORE_DEFINES_SVH
`define ROTATING_KEY_XOR_CIPHER_CORE_DEFINES_SVH
`ifndef SYNTH
// Check prop at each rising clock edge outside reset.
`define RKX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check prop at each rising clock edge, reset included.
`define RKX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RKX_ASSERT(lbl, prop, msg)
`define RKX_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[sv/rkx_pkg.sv]
// Shared types and constants for the rotating key XOR cipher core.
`default_nettype none
package rkx_pkg;

  // Default number of working key bytes.
  localparam int KEY_BYTES_DEF = 32;

  // Configured key storage: four 64-bit words, byte 0 in the top bits.
  localparam int CFG_KEY_BYTES = 32;
  localparam int CFG_KEY_BITS  = CFG_KEY_BYTES * 8;
  localparam int KLEN_W        = 6;

  // APB port sizes.
  localparam int APB_ADDR_W = 6;
  localparam int APB_DATA_W = 64;
  localparam int REG_IDX_W  = 3;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_KEY_WORD_0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KEY_WORD_1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KEY_WORD_2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KEY_WORD_3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KEY_LENGTH = 3'd4;

  // Configuration handed from the register file to the datapath.
  typedef struct packed {
    logic [CFG_KEY_BITS-1:0] key;
    logic [KLEN_W-1:0]       key_length;
  } cfg_t;

  // One plaintext transaction.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } item_t;

endpackage
`default_nettype wire

[sv/rotating_key_xor_cipher_core.sv]
// Each byte passes through two registers, the input register and the result register.
// Throughput: one byte per cycle while the output is not stalled; the key rotate and XOR
// fit between the two registers. A result waiting at the output stalls the result register;
// the input register still takes one more transaction. Reset (rst_n low, synchronous)
// clears the key registers, sets key_length to 1 and arms a key reload for the first byte.
`default_nettype none
module rotating_key_xor_cipher_core #(
  parameter int KEY_BYTES = rkx_pkg::KEY_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [7:0]                     in_data_byte,
  input  wire logic                           in_end_of_message,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [7:0]                          out_cipher_byte,
  output logic                                out_last_byte,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [rkx_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [rkx_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [rkx_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);

  rkx_pkg::cfg_t  cfg;
  rkx_pkg::item_t in_item_r;
  logic           in_valid_r;
  logic           s_ready;

  rkx_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input register: take a transaction whenever it is empty or draining.
  assign in_ready = !in_valid_r || s_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r.data_byte      <= in_data_byte;
      in_item_r.end_of_message <= in_end_of_message;
    end
  end

  rkx_crypt #(
    .KEY_BYTES (KEY_BYTES)
  ) u_crypt (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .s_valid         (in_valid_r),
    .s_item          (in_item_r),
    .s_ready         (s_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_cipher_byte (out_cipher_byte),
    .out_last_byte   (out_last_byte)
  );

endmodule
`default_nettype wire

[sv/rkx_regs.sv]
// APB register file holding the configured key and key length.
`default_nettype none
module rkx_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [rkx_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [rkx_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [rkx_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready,
  output rkx_pkg::cfg_t                         cfg
);

  logic [rkx_pkg::APB_DATA_W-1:0] key_word_r [4];
  logic [rkx_pkg::KLEN_W-1:0]     key_length_r;
  logic [rkx_pkg::REG_IDX_W-1:0]  reg_idx;
  logic                           wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[rkx_pkg::APB_ADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite;

  // Write registers on the APB access cycle; unknown indexes drop.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_word_r[0] <= '0;
      key_word_r[1] <= '0;
      key_word_r[2] <= '0;
      key_word_r[3] <= '0;
      key_length_r  <= rkx_pkg::KLEN_W'(1);
    end else if (wr_en) begin
      case (reg_idx)
        rkx_pkg::REG_KEY_WORD_0: key_word_r[0] <= pwdata;
        rkx_pkg::REG_KEY_WORD_1: key_word_r[1] <= pwdata;
        rkx_pkg::REG_KEY_WORD_2: key_word_r[2] <= pwdata;
        rkx_pkg::REG_KEY_WORD_3: key_word_r[3] <= pwdata;
        rkx_pkg::REG_KEY_LENGTH: key_length_r  <= pwdata[rkx_pkg::KLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Return the addressed register on reads.
  always_comb begin
    case (reg_idx)
      rkx_pkg::REG_KEY_WORD_0: prdata = key_word_r[0];
      rkx_pkg::REG_KEY_WORD_1: prdata = key_word_r[1];
      rkx_pkg::REG_KEY_WORD_2: prdata = key_word_r[2];
      rkx_pkg::REG_KEY_WORD_3: prdata = key_word_r[3];
      rkx_pkg::REG_KEY_LENGTH: prdata = rkx_pkg::APB_DATA_W'(key_length_r);
      default:                 prdata = '0;
    endcase
  end

  assign cfg.key        = {key_word_r[0], key_word_r[1], key_word_r[2], key_word_r[3]};
  assign cfg.key_length = key_length_r;

endmodule
`default_nettype wire

[sv/rkx_crypt.sv]
// Working key state, byte XOR and key rotation, with the result register.
`default_nettype none
`include "rotating_key_xor_cipher_core_defines.svh"
module rkx_crypt #(
  parameter int KEY_BYTES = rkx_pkg::KEY_BYTES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rkx_pkg::cfg_t  cfg,
  input  wire logic           s_valid,
  input  wire rkx_pkg::item_t s_item,
  output logic                s_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_cipher_byte,
  output logic                out_last_byte
);

  localparam int KW    = KEY_BYTES * 8;
  localparam int POS_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int LEN_W = $clog2(KEY_BYTES + 1);
  localparam int EXT_W = rkx_pkg::KLEN_W + 1;

  logic [KW-1:0]    wk_r;
  logic [POS_W-1:0] pos_r;
  logic [LEN_W-1:0] len_r;
  logic             msg_start_r;
  logic             out_valid_r;
  logic [7:0]       cipher_r;
  logic             last_r;

  logic [EXT_W-1:0] klen_ext;
  logic [LEN_W-1:0] eff_len;
  logic [LEN_W-1:0] cur_len;
  logic [POS_W-1:0] cur_pos;
  logic [KW-1:0]    cfg_key;
  logic [KW-1:0]    cur_key;
  logic [KW-1:0]    rot_key;
  logic [KW-1:0]    len_mask;
  logic [7:0]       key_byte;
  logic             end_blk;
  logic             adv;

  // Clamp the configured length to 1..KEY_BYTES.
  assign klen_ext = EXT_W'(cfg.key_length);
  always_comb begin
    if (klen_ext == '0) begin
      eff_len = LEN_W'(1);
    end else if (klen_ext > EXT_W'(KEY_BYTES)) begin
      eff_len = LEN_W'(KEY_BYTES);
    end else begin
      eff_len = LEN_W'(klen_ext);
    end
  end

  assign cur_len = msg_start_r ? eff_len : len_r;
  assign cur_pos = msg_start_r ? '0 : pos_r;

  // Load bytes in use from the configured key; the rest stay zero.
  for (genvar i = 0; i < KEY_BYTES; i++) begin : g_load
    if (i < rkx_pkg::CFG_KEY_BYTES) begin : g_reg
      assign cfg_key[KW-1-8*i -: 8] = (LEN_W'(i) < eff_len) ?
          cfg.key[rkx_pkg::CFG_KEY_BITS-1-8*i -: 8] : 8'h00;
    end else begin : g_zero
      assign cfg_key[KW-1-8*i -: 8] = 8'h00;
    end
    assign len_mask[KW-1-8*i -: 8] = (LEN_W'(i) < len_r) ? 8'hFF : 8'h00;
  end

  assign cur_key = msg_start_r ? cfg_key : wk_r;

  // Pick the key byte at the current position.
  always_comb begin
    key_byte = 8'h00;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (POS_W'(i) == cur_pos) begin
        key_byte = cur_key[KW-1-8*i -: 8];
      end
    end
  end

  // Rotate the in-use bytes left by one bit; the top bit wraps to the last byte.
  always_comb begin
    rot_key = cur_key << 1;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (LEN_W'(i + 1) == cur_len) begin
        rot_key[KW-8*(i+1)] = cur_key[KW-1];
      end
    end
  end

  assign end_blk = (LEN_W'(cur_pos) + LEN_W'(1)) == cur_len;
  assign s_ready = !out_valid_r || out_ready;
  assign adv     = s_valid && s_ready;

  // Advance key state on each transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wk_r        <= '0;
      pos_r       <= '0;
      len_r       <= LEN_W'(1);
      msg_start_r <= 1'b1;
    end else if (adv) begin
      wk_r        <= end_blk ? rot_key : cur_key;
      pos_r       <= end_blk ? '0 : cur_pos + POS_W'(1);
      len_r       <= cur_len;
      msg_start_r <= s_item.end_of_message;
    end
  end

  // Hold the result until the sink takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s_ready) begin
      out_valid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cipher_r <= s_item.data_byte ^ key_byte;
      last_r   <= s_item.end_of_message;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cipher_byte = cipher_r;
  assign out_last_byte   = last_r;

  `RKX_ASSERT_ALWAYS(a_reset_state, !rst_n |=> (msg_start_r && pos_r == '0), "reset state wrong")
  `RKX_ASSERT(a_pos_in_block, msg_start_r || (LEN_W'(pos_r) < len_r), "position past block")
  `RKX_ASSERT(a_eom_restart, (adv && s_item.end_of_message) |=> msg_start_r, "no restart after end")
  `RKX_ASSERT(a_unused_zero, msg_start_r || ((wk_r & ~len_mask) == '0), "unused key bits set")

endmodule
`default_nettype wire
